// ===== rtl/dq_pkg.sv =====
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic push_wr;
    logic fail;
    logic pop_rd;
    logic pop_done;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fail;
    logic is_pop;
  } dp_stat_t;

  // (base + offset) mod DEPTH, both below DEPTH
  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] offset);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (ADDR_W + 1)'(DEPTH)) begin
      sum = sum - (ADDR_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/dq_ram.sv =====
`timescale 1ns / 1ps

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dq_ctrl.sv =====
`timescale 1ns / 1ps

module dq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dq_pkg::dp_stat_t  stat,
  output dq_pkg::dp_cmd_t   cmd,
  output logic              busy,
  output logic              done
);

  dq_pkg::state_t state, state_next;
  logic           done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    unique case (state)
      dq_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = dq_pkg::S_EXEC;
        end
      end
      dq_pkg::S_EXEC: begin
        if (stat.fail) begin
          cmd.fail   = 1'b1;
          done_next  = 1'b1;
          state_next = dq_pkg::S_IDLE;
        end else if (stat.is_pop) begin
          cmd.pop_rd = 1'b1;
          state_next = dq_pkg::S_POP;
        end else begin
          cmd.push_wr = 1'b1;
          done_next   = 1'b1;
          state_next  = dq_pkg::S_IDLE;
        end
      end
      dq_pkg::S_POP: begin
        cmd.pop_done = 1'b1;
        done_next    = 1'b1;
        state_next   = dq_pkg::S_IDLE;
      end
      default: begin
        state_next = dq_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != dq_pkg::S_IDLE);

endmodule

// ===== rtl/dq_dp.sv =====
`timescale 1ns / 1ps

module dq_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  dq_pkg::dp_cmd_t             cmd,
  input  logic [1:0]                  command,
  input  logic signed [31:0]          value,
  output dq_pkg::dp_stat_t            stat,
  output logic signed [31:0]          popped_value,
  output logic [1:0]                  status,
  output logic [dq_pkg::OCC_W-1:0]    occupancy,
  output logic                        empty_res
);

  localparam int AW = dq_pkg::ADDR_W;
  localparam int CW = dq_pkg::CNT_W;

  dq_pkg::cmd_t             cmd_q;
  logic [dq_pkg::DATA_W-1:0] val_q;
  logic [AW-1:0]            front;
  logic [CW-1:0]            count;
  logic [AW-1:0]            slot;
  logic [CW-1:0]            count_dec;
  logic [CW-1:0]            count_inc;
  logic                     full;
  logic                     empty;
  logic                     is_pop;
  logic [dq_pkg::DATA_W-1:0] rdata;

  assign full      = (count == CW'(dq_pkg::DEPTH));
  assign empty     = (count == '0);
  assign is_pop    = (cmd_q == dq_pkg::CMD_POP_FRONT) || (cmd_q == dq_pkg::CMD_POP_REAR);
  assign count_dec = count - CW'(1);
  assign count_inc = count + CW'(1);

  assign stat.is_pop = is_pop;
  assign stat.fail   = is_pop ? empty : full;

  always_comb begin
    case (cmd_q)
      dq_pkg::CMD_PUSH_FRONT: slot = dq_pkg::ring_add(front, AW'(dq_pkg::DEPTH - 1));
      dq_pkg::CMD_PUSH_REAR:  slot = dq_pkg::ring_add(front, count[AW-1:0]);
      dq_pkg::CMD_POP_FRONT:  slot = front;
      default:                slot = dq_pkg::ring_add(front, count_dec[AW-1:0]);
    endcase
  end

  dq_ram #(
    .WIDTH(dq_pkg::DATA_W),
    .DEPTH(dq_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.push_wr),
    .waddr(slot),
    .wdata(val_q),
    .re   (cmd.pop_rd),
    .raddr(slot),
    .rdata(rdata)
  );

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.push_wr) begin
      if (cmd_q == dq_pkg::CMD_PUSH_FRONT) begin
        front <= slot;
      end
      count <= count_inc;
    end else if (cmd.pop_done) begin
      if (cmd_q == dq_pkg::CMD_POP_FRONT) begin
        front <= dq_pkg::ring_add(front, AW'(1));
      end
      count <= count_dec;
    end
  end

  // latched item and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= dq_pkg::cmd_t'(command);
      val_q <= value;
    end
    if (cmd.push_wr) begin
      popped_value <= '0;
      status       <= dq_pkg::ST_OK;
      occupancy    <= dq_pkg::OCC_W'(count_inc);
      empty_res    <= 1'b0;
    end else if (cmd.fail) begin
      popped_value <= '0;
      status       <= is_pop ? dq_pkg::ST_UNDERFLOW : dq_pkg::ST_OVERFLOW;
      occupancy    <= dq_pkg::OCC_W'(count);
      empty_res    <= empty;
    end else if (cmd.pop_done) begin
      popped_value <= rdata;
      status       <= dq_pkg::ST_OK;
      occupancy    <= dq_pkg::OCC_W'(count_dec);
      empty_res    <= (count_dec == '0);
    end
  end

endmodule

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values in a ring buffer of
// dq_pkg::DEPTH entries. Drive command and value with start high while busy
// is low; the item is taken at that edge. The result (popped_value, status,
// occupancy, empty_res) appears with done high for exactly one cycle and
// cannot be held off, so capture it when done is seen. A push or any failed
// command passes through the execute state only; a successful pop also passes
// through a pop state, for the registered read of the entry store.
// busy drops in the cycle done is high, so the next item may be offered then.
// Pop on an empty queue reports underflow with zero data, push on a full
// queue reports overflow and drops the value; neither changes the queue.

module double_ended_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               command,
  input  logic signed [31:0]       value,
  output logic                     done,
  output logic signed [31:0]       popped_value,
  output logic [1:0]               status,
  output logic [dq_pkg::OCC_W-1:0] occupancy,
  output logic                     empty_res
);

  // command and status between controller and datapath
  dq_pkg::dp_cmd_t  dp_cmd;
  dq_pkg::dp_stat_t dp_stat;

  // sequencer: accept, execute, optional store read
  dq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (dp_stat),
    .cmd  (dp_cmd),
    .busy (busy),
    .done (done)
  );

  // ring pointers, entry store and result registers
  dq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .command     (command),
    .value       (value),
    .stat        (dp_stat),
    .popped_value(popped_value),
    .status      (status),
    .occupancy   (occupancy),
    .empty_res   (empty_res)
  );

  // an accepted item keeps the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  // every item passes through the execute state before its result, so done is never held high
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // underflow only happens on an empty queue, which stays empty
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    done && status == 2'(dq_pkg::ST_UNDERFLOW) |-> empty_res && occupancy == '0)
    else $error("underflow reported on a non-empty queue");

  // overflow only happens on a full queue
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    done && status == 2'(dq_pkg::ST_OVERFLOW) |->
      occupancy == dq_pkg::OCC_W'(dq_pkg::DEPTH) && !empty_res)
    else $error("overflow reported on a queue that is not full");

  // a result is only presented after a busy cycle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a preceding busy cycle");

endmodule

// ===== verif/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps

module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no item taken and no result
  localparam int DRAIN_CYCLES = 10;    // longest item goes through execute and pop
  localparam int RANDOM_ITEMS = 900;

  // one result of the deque as the checker sees it
  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           st;
    logic [OCC_W-1:0]  occ;
    logic              empty;
  } deque_result_t;

  // one row of the directed table; a row may repeat its command with value + k
  typedef struct {
    cmd_t          cmd;
    logic [31:0]   val;
    int            reps;
    bit            typed;
    deque_result_t res;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               command = CMD_PUSH_FRONT;
  logic signed [31:0]       value = '0;
  logic                     done;
  logic signed [31:0]       popped_value;
  logic [1:0]               status;
  logic [OCC_W-1:0]         occupancy;
  logic                     empty_res;

  // typed expectation travels alongside the item, sampled at accept like an input
  bit                       row_typed = 1'b0;
  deque_result_t            row_res = '0;

  // shadow copy of the ring, kept by the predictor
  logic [DATA_W-1:0]        shadow_ring [DEPTH];
  int                       shadow_head = 0;
  int                       shadow_fill = 0;

  deque_result_t            pending_results [$];
  int                       errors = 0;
  int                       items_taken = 0;
  int                       overflow_seen = 0;
  int                       underflow_seen = 0;
  int                       peak_fill = 0;
  int                       stall_cnt = 0;
  bit                       idle_en = 1'b1;

  double_ended_queue dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .value        (value),
    .done         (done),
    .popped_value (popped_value),
    .status       (status),
    .occupancy    (occupancy),
    .empty_res    (empty_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor: applies one command to the shadow ring and returns its result
  function automatic deque_result_t deque_step(input cmd_t c, input logic [DATA_W-1:0] v);
    deque_result_t r;
    int slot;
    r = '0;
    r.st = ST_OK;
    case (c)
      CMD_PUSH_FRONT: begin
        if (shadow_fill == DEPTH) begin
          r.st = ST_OVERFLOW;
        end else begin
          // front moves back one slot, wrapping below zero
          shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
          shadow_ring[shadow_head] = v;
          shadow_fill++;
        end
      end
      CMD_PUSH_REAR: begin
        if (shadow_fill == DEPTH) begin
          r.st = ST_OVERFLOW;
        end else begin
          slot = (shadow_head + shadow_fill) % DEPTH;
          shadow_ring[slot] = v;
          shadow_fill++;
        end
      end
      CMD_POP_FRONT: begin
        if (shadow_fill == 0) begin
          r.st = ST_UNDERFLOW;
        end else begin
          r.data = shadow_ring[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_fill--;
        end
      end
      default: begin
        // rear pop only shortens the queue, the front stays put
        if (shadow_fill == 0) begin
          r.st = ST_UNDERFLOW;
        end else begin
          slot = (shadow_head + shadow_fill - 1) % DEPTH;
          r.data = shadow_ring[slot];
          shadow_fill--;
        end
      end
    endcase
    r.occ   = OCC_W'(shadow_fill);
    r.empty = (shadow_fill == 0);
    if (r.st == ST_OVERFLOW) overflow_seen++;
    if (r.st == ST_UNDERFLOW) underflow_seen++;
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    return r;
  endfunction

  // result check first, then prediction for an item taken at the same edge
  always @(posedge clk) begin : result_check
    deque_result_t want;
    deque_result_t pred;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: popped_value %h status %0d occupancy %0d",
                 popped_value, status, occupancy);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (popped_value !== want.data) begin
            $error("popped_value: expected %h, got %h", want.data, popped_value);
            errors++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            errors++;
          end
          if (occupancy !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
            errors++;
          end
          if (empty_res !== want.empty) begin
            $error("empty_res: expected %0d, got %0d", want.empty, empty_res);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        items_taken++;
        pred = deque_step(cmd_t'(command), value);
        // a hand-typed row must agree with the predictor as well
        if (row_typed && pred !== row_res) begin
          $error("directed row: typed %h, predicted %h", row_res, pred);
          errors++;
        end
        pending_results.push_back(row_typed ? row_res : pred);
      end
    end
  end

  // watchdog: any item taken or result seen restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // offer one item, with random idle cycles ahead of it, and hold it until taken
  task automatic offer(input cmd_t c, input logic [31:0] v, input bit typed,
                       input deque_result_t r);
    while (idle_en && $urandom_range(99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    command   <= c;
    value     <= v;
    row_typed <= typed;
    row_res   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start and wait for every outstanding result
  task automatic drain;
    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    @(posedge clk);
  endtask

  function automatic stim_row_t row(input cmd_t c, input logic [31:0] v, input int n,
                                    input bit typed, input logic [31:0] d,
                                    input status_t s, input int o, input bit e);
    stim_row_t t;
    t.cmd       = c;
    t.val       = v;
    t.reps      = n;
    t.typed     = typed;
    t.res       = '0;
    t.res.data  = d;
    t.res.st    = s;
    t.res.occ   = OCC_W'(o);
    t.res.empty = e;
    return t;
  endfunction

  initial begin : stimulus
    stim_row_t     dir_table [$];
    deque_result_t none;
    int            push_pct;
    int            pick;
    cmd_t          c;
    logic [31:0]   v;
    none = '0;

    // pops on the empty queue right after reset, extremes in and out at both ends
    dir_table.push_back(row(CMD_POP_FRONT,  32'h0000_0000, 1, 1, 32'h0, ST_UNDERFLOW, 0, 1));
    dir_table.push_back(row(CMD_POP_REAR,   32'hFFFF_FFFF, 1, 1, 32'h0, ST_UNDERFLOW, 0, 1));
    dir_table.push_back(row(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1, 1, 32'h0, ST_OK, 1, 0));
    dir_table.push_back(row(CMD_POP_REAR,   32'h0000_0000, 1, 1, 32'h7FFF_FFFF, ST_OK, 0, 1));
    dir_table.push_back(row(CMD_PUSH_REAR,  32'h8000_0000, 1, 1, 32'h0, ST_OK, 1, 0));
    dir_table.push_back(row(CMD_POP_FRONT,  32'h0000_0000, 1, 1, 32'h8000_0000, ST_OK, 0, 1));
    // mixed ends, checked by the predictor
    dir_table.push_back(row(CMD_PUSH_REAR,  32'hFFFF_FFFF, 1, 0, 32'h0, ST_OK, 0, 0));
    dir_table.push_back(row(CMD_PUSH_FRONT, 32'h0000_0000, 1, 0, 32'h0, ST_OK, 0, 0));
    dir_table.push_back(row(CMD_PUSH_FRONT, 32'h5555_5555, 1, 0, 32'h0, ST_OK, 0, 0));
    dir_table.push_back(row(CMD_POP_REAR,   32'hAAAA_AAAA, 1, 0, 32'h0, ST_OK, 0, 0));
    dir_table.push_back(row(CMD_POP_FRONT,  32'h0000_0000, 1, 0, 32'h0, ST_OK, 0, 0));
    dir_table.push_back(row(CMD_POP_FRONT,  32'h0000_0000, 1, 0, 32'h0, ST_OK, 0, 0));
    // fill from both ends, so the front wraps, then push onto the full queue
    dir_table.push_back(row(CMD_PUSH_FRONT, 32'h1000_0000, DEPTH / 2, 0, 32'h0, ST_OK, 0, 0));
    dir_table.push_back(row(CMD_PUSH_REAR,  32'h2000_0000, DEPTH / 2, 0, 32'h0, ST_OK, 0, 0));
    dir_table.push_back(row(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1, 1, 32'h0, ST_OVERFLOW, DEPTH, 0));
    dir_table.push_back(row(CMD_PUSH_REAR,  32'h8000_0000, 1, 1, 32'h0, ST_OVERFLOW, DEPTH, 0));
    // empty it again from both ends, then one more rear pop
    dir_table.push_back(row(CMD_POP_REAR,   32'h0000_0000, DEPTH / 2, 0, 32'h0, ST_OK, 0, 0));
    dir_table.push_back(row(CMD_POP_FRONT,  32'h0000_0000, DEPTH / 2, 0, 32'h0, ST_OK, 0, 0));
    dir_table.push_back(row(CMD_POP_REAR,   32'h0000_0000, 1, 1, 32'h0, ST_UNDERFLOW, 0, 1));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      for (int k = 0; k < dir_table[i].reps; k++) begin
        offer(dir_table[i].cmd, dir_table[i].val + k, dir_table[i].typed, dir_table[i].res);
      end
    end

    // random part: bursts that lean toward pushes, pops or neither,
    // so the queue swings between full and empty
    push_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        pick = $urandom_range(2);
        push_pct = (pick == 0) ? 80 : (pick == 1) ? 20 : 50;
      end
      idle_en = !(i >= 300 && i < 500);  // a long back-to-back stretch
      if (i == 450) drain();
      if ($urandom_range(99) < push_pct) begin
        c = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
      end else begin
        c = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
      end
      // corner values now and then, fully random words otherwise
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end else begin
        v = $urandom;
      end
      offer(c, v, 1'b0, none);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end

    $display("covered %0d items on a %0d-entry ring: %0d overflows, %0d underflows",
             items_taken, DEPTH, overflow_seen, underflow_seen);
    $display("peak occupancy %0d, %0d mismatches", peak_fill, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
